[rtl/fcf_pkg.sv]
// Shared types and constants for the four channel FIR filter.
package fcf_pkg;

    localparam int CHANNELS  = 4;
    localparam int CH_W      = 2;
    localparam int SAMPLE_W  = 16;
    localparam int TAP_W     = 16;
    localparam int OUT_W     = 20;
    localparam int PROD_W    = 32;
    localparam int FRAC_W    = 14;
    localparam int MAX_TAPS  = 8;
    localparam int TAP_IDX_W = 3;
    localparam int CFG_IDX_W = 4;
    localparam int TAP_RESET = 2048;
    localparam int OUT_MAX   = 524287;
    localparam int OUT_MIN   = -524288;

    // Channel slots within one delay line word.
    localparam int CH_FRONT_LEFT  = 0;
    localparam int CH_FRONT_RIGHT = 1;
    localparam int CH_REAR_LEFT   = 2;
    localparam int CH_REAR_RIGHT  = 3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [TAP_W-1:0]    tap_t;
    typedef logic signed [OUT_W-1:0]    result_t;

    typedef sample_t [CHANNELS-1:0] hist_word_t;
    typedef tap_t    [MAX_TAPS-1:0] tap_vec_t;
    typedef result_t [CHANNELS-1:0] result_vec_t;

    // Control tag that travels with each read through the MAC pipeline.
    typedef struct packed {
        logic                 vld;
        logic [CH_W-1:0]      ch;
        logic [TAP_IDX_W-1:0] tap;
        logic                 first;
        logic                 last;
    } mac_tag_t;

endpackage

[rtl/fcf_hist_mem.sv]
// Delay line memory: one word of four samples per age slot, registered read data.
module fcf_hist_mem #(
    parameter int DEPTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  fcf_pkg::hist_word_t wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output fcf_pkg::hist_word_t rd_data
);
    import fcf_pkg::*;

    hist_word_t       mem [DEPTH];
    hist_word_t       rd_word_reg;
    logic [DEPTH-1:0] vld_reg;
    logic             rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    // Slots never written read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_word_reg : '0;

endmodule

[rtl/fcf_mac.sv]
// Shared multiply-accumulate pipeline with floor shift and saturation per channel.
module fcf_mac #(
    parameter int TAP_COUNT = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fcf_pkg::mac_tag_t    tag_in,
    input  fcf_pkg::hist_word_t  rd_data,
    input  fcf_pkg::tap_vec_t    taps,
    output logic                 done,
    output fcf_pkg::result_vec_t res
);
    import fcf_pkg::*;

    localparam int ACC_W = PROD_W + $clog2(TAP_COUNT);
    localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(OUT_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(OUT_MIN);
    localparam logic signed [ACC_W-1:0] ACC_ZERO = '0;

    mac_tag_t                  tag1_reg;
    mac_tag_t                  tag2_reg;
    mac_tag_t                  tag3_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_base;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   shifted;
    result_t                   sat_val;
    result_vec_t               res_reg;

    always_comb
    begin
        prod_next = $signed(rd_data[tag1_reg.ch]) * $signed(taps[tag1_reg.tap]);
        acc_base  = tag2_reg.first ? ACC_ZERO : acc_reg;
        acc_next  = acc_base + ACC_W'(prod_reg);
        shifted   = acc_reg >>> FRAC_W;
        priority if (shifted > SAT_HI)
        begin
            sat_val = OUT_W'(OUT_MAX);
        end
        else if (shifted < SAT_LO)
        begin
            sat_val = OUT_W'(OUT_MIN);
        end
        else
        begin
            sat_val = shifted[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag1_reg.vld)
        begin
            prod_reg <= prod_next;
        end
        if (tag2_reg.vld)
        begin
            acc_reg <= acc_next;
        end
        if (tag3_reg.vld && tag3_reg.last)
        begin
            res_reg[tag3_reg.ch] <= sat_val;
        end
    end

    assign done = tag3_reg.vld && tag3_reg.last && (tag3_reg.ch == CH_W'(CHANNELS - 1));
    assign res  = res_reg;

endmodule

[rtl/fcf_seq.sv]
// Sequencer: write position, fill flag and read order over channels and taps.
module fcf_seq #(
    parameter int TAP_COUNT = 8,
    localparam int AW = $clog2(TAP_COUNT)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_free,
    input  logic              done,
    output logic              load,
    output logic              full,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic              rd_en,
    output logic [AW-1:0]     rd_addr,
    output fcf_pkg::mac_tag_t tag
);
    import fcf_pkg::*;

    localparam logic [AW-1:0] POS_LAST  = AW'(TAP_COUNT - 1);
    localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(TAP_COUNT);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_HOLD
    } state_t;

    state_t          state_reg;
    logic [AW-1:0]   wp_reg;
    logic [AW-1:0]   base_reg;
    logic [AW-1:0]   k_reg;
    logic [CH_W-1:0] ch_reg;
    logic            full_reg;
    logic            wp_last;
    logic            k_last;
    logic [AW:0]     diff;
    logic [AW:0]     addr_ext;

    always_comb
    begin
        wp_last  = (wp_reg == POS_LAST);
        k_last   = (k_reg == POS_LAST);
        diff     = {1'b0, base_reg} - {1'b0, k_reg};
        addr_ext = (base_reg < k_reg) ? diff + DEPTH_EXT : diff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wp_reg    <= '0;
            base_reg  <= '0;
            k_reg     <= '0;
            ch_reg    <= '0;
            full_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        base_reg  <= wp_reg;
                        wp_reg    <= wp_last ? '0 : wp_reg + AW'(1);
                        full_reg  <= full_reg | wp_last;
                        k_reg     <= '0;
                        ch_reg    <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (k_last)
                    begin
                        k_reg <= '0;
                        if (ch_reg == CH_W'(CHANNELS - 1))
                        begin
                            state_reg <= ST_DRAIN;
                        end
                        else
                        begin
                            ch_reg <= ch_reg + CH_W'(1);
                        end
                    end
                    else
                    begin
                        k_reg <= k_reg + AW'(1);
                    end
                end
                ST_DRAIN:
                begin
                    if (done)
                    begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign wr_en     = in_valid && in_ready;
    assign wr_addr   = wp_reg;
    assign rd_en     = (state_reg == ST_RUN);
    assign rd_addr   = addr_ext[AW-1:0];
    assign load      = (state_reg == ST_HOLD) && out_free;
    assign full      = full_reg;
    assign tag.vld   = rd_en;
    assign tag.ch    = ch_reg;
    assign tag.tap   = TAP_IDX_W'(k_reg);
    assign tag.first = (k_reg == '0);
    assign tag.last  = k_last;

endmodule

[rtl/four_channel_fir_filter.sv]
// Top level of the four channel FIR filter: tap registers, delay memory, MAC and output register.
//
// Four-channel direct-form FIR filter for load cell forces. Each input transfer carries
// one signed 16-bit sample per channel; the samples go into an 8-slot (TAP_COUNT-slot)
// delay memory that holds all four channels in one word, and each channel's result is
// the sum of tap_k times the sample k transfers old, shifted right by 14 with floor
// rounding and saturated to signed 20 bits. Slots not yet written since reset count as
// zero. history_full rises with the TAP_COUNT-th transfer after reset and stays high.
// Taps are signed Q2.14 words written through the cfg port at index 0..7 (reset 0.125);
// writes to other indexes are dropped. Write taps only while no item is in flight.
// One multiplier is shared over every channel and tap, one memory read per product, so
// the next transfer in is taken only after the item's result is loaded into the output
// register. The output register holds a finished result while the next item is already
// being filtered.
module four_channel_fir_filter #(
    parameter int TAP_COUNT = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  fcf_pkg::sample_t                 front_left_sample,
    input  fcf_pkg::sample_t                 front_right_sample,
    input  fcf_pkg::sample_t                 rear_left_sample,
    input  fcf_pkg::sample_t                 rear_right_sample,
    output logic                             out_valid,
    input  logic                             out_ready,
    output fcf_pkg::result_t                 front_left_filtered,
    output fcf_pkg::result_t                 front_right_filtered,
    output fcf_pkg::result_t                 rear_left_filtered,
    output fcf_pkg::result_t                 rear_right_filtered,
    output logic                             history_full,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fcf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  fcf_pkg::tap_t                    cfg_data
);
    import fcf_pkg::*;

    localparam int AW = $clog2(TAP_COUNT);

    tap_vec_t    tap_reg;
    hist_word_t  wr_word;
    hist_word_t  rd_word;
    mac_tag_t    seq_tag;
    result_vec_t mac_res;
    result_vec_t out_res_reg;
    logic        out_full_reg;
    logic        out_valid_reg;
    logic        out_free;
    logic        load;
    logic        full;
    logic        done;
    logic        wr_en;
    logic        rd_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    // Tap registers; the config port never stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= {MAX_TAPS{TAP_W'(TAP_RESET)}};
        end
        else if (cfg_valid && (cfg_index < CFG_IDX_W'(MAX_TAPS)))
        begin
            tap_reg[cfg_index[TAP_IDX_W-1:0]] <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    // Pack the four channel samples into one delay line word.
    assign wr_word[CH_FRONT_LEFT]  = front_left_sample;
    assign wr_word[CH_FRONT_RIGHT] = front_right_sample;
    assign wr_word[CH_REAR_LEFT]   = rear_left_sample;
    assign wr_word[CH_REAR_RIGHT]  = rear_right_sample;

    fcf_seq #(
        .TAP_COUNT (TAP_COUNT)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_free (out_free),
        .done     (done),
        .load     (load),
        .full     (full),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .tag      (seq_tag)
    );

    fcf_hist_mem #(
        .DEPTH (TAP_COUNT)
    ) u_hist_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_word),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    fcf_mac #(
        .TAP_COUNT (TAP_COUNT)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (seq_tag),
        .rd_data (rd_word),
        .taps    (tap_reg),
        .done    (done),
        .res     (mac_res)
    );

    // Output register: load when empty or when the waiting result transfers out.
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_res_reg  <= mac_res;
            out_full_reg <= full;
        end
    end

    assign out_valid            = out_valid_reg;
    assign front_left_filtered  = out_res_reg[CH_FRONT_LEFT];
    assign front_right_filtered = out_res_reg[CH_FRONT_RIGHT];
    assign rear_left_filtered   = out_res_reg[CH_REAR_LEFT];
    assign rear_right_filtered  = out_res_reg[CH_REAR_RIGHT];
    assign history_full         = out_full_reg;

    // An accepted item starts issuing reads in the very next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> seq_tag.vld)
        else $error("read sequence did not start after input transfer");

    // A result is never loaded over one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten before transfer");

    // The fill flag never drops once set.
    assert property (@(posedge clk) disable iff (!rst_n)
        history_full |=> history_full)
        else $error("history_full fell");

endmodule

[tb/fcf_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the four channel FIR filter: predicts every result and checks each output transfer.
module fcf_checker #(
    parameter int TAP_COUNT = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  fcf_pkg::sample_t              front_left_sample,
    input  fcf_pkg::sample_t              front_right_sample,
    input  fcf_pkg::sample_t              rear_left_sample,
    input  fcf_pkg::sample_t              rear_right_sample,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  fcf_pkg::result_t              front_left_filtered,
    input  fcf_pkg::result_t              front_right_filtered,
    input  fcf_pkg::result_t              rear_left_filtered,
    input  fcf_pkg::result_t              rear_right_filtered,
    input  logic                          history_full,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [fcf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  fcf_pkg::tap_t                 cfg_data,
    output int                            outstanding,
    output int                            fail_count
);

    typedef struct packed {
        fcf_pkg::result_vec_t filt;
        logic                 full;
    } fir_out_t;

    fcf_pkg::tap_t      coef [fcf_pkg::MAX_TAPS];
    fcf_pkg::hist_word_t delay_line [fcf_pkg::MAX_TAPS];
    int                 slot;
    logic               window_full;

    fir_out_t            expected_q [$];
    fir_out_t            got;
    fir_out_t            want;
    fcf_pkg::hist_word_t in_word;
    int                  n_predicted;
    int                  n_checked;
    int                  errors;

    string ch_name [fcf_pkg::CHANNELS] = '{"front_left", "front_right", "rear_left", "rear_right"};

    assign outstanding = n_predicted - n_checked;
    assign fail_count  = errors;

    function automatic fcf_pkg::result_t clip20(input longint v);
        if (v > fcf_pkg::OUT_MAX)
            return fcf_pkg::result_t'(fcf_pkg::OUT_MAX);
        if (v < fcf_pkg::OUT_MIN)
            return fcf_pkg::result_t'(fcf_pkg::OUT_MIN);
        return fcf_pkg::result_t'(v);
    endfunction

    // Store the new word, then sum tap k against the sample k transfers old.
    function automatic fir_out_t filter_step(input fcf_pkg::hist_word_t word);
        fir_out_t         r;
        longint           acc;
        int               idx;
        fcf_pkg::sample_t s;
        delay_line[slot] = word;
        for (int c = 0; c < fcf_pkg::CHANNELS; c++)
        begin
            acc = 0;
            for (int k = 0; k < TAP_COUNT; k++)
            begin
                idx = (slot + TAP_COUNT - k) % TAP_COUNT;
                s = delay_line[idx][c];
                acc += longint'(s) * longint'(coef[k]);
            end
            r.filt[c] = clip20(acc >>> fcf_pkg::FRAC_W);
        end
        slot = (slot + 1) % TAP_COUNT;
        if (slot == 0)
            window_full = 1'b1;
        r.full = window_full;
        return r;
    endfunction

    initial
    begin
        errors = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < fcf_pkg::MAX_TAPS; k++)
            begin
                coef[k]       = fcf_pkg::tap_t'(fcf_pkg::TAP_RESET);
                delay_line[k] = '0;
            end
            slot        = 0;
            window_full = 1'b0;
            expected_q.delete();
            n_predicted <= 0;
            n_checked   <= 0;
        end
        else
        begin
            // Drop writes to indexes past the last tap.
            if (cfg_valid && cfg_ready &&
                cfg_index < fcf_pkg::CFG_IDX_W'(fcf_pkg::MAX_TAPS))
                coef[cfg_index[fcf_pkg::TAP_IDX_W-1:0]] = cfg_data;

            if (out_valid && out_ready)
            begin
                got.filt[fcf_pkg::CH_FRONT_LEFT]  = front_left_filtered;
                got.filt[fcf_pkg::CH_FRONT_RIGHT] = front_right_filtered;
                got.filt[fcf_pkg::CH_REAR_LEFT]   = rear_left_filtered;
                got.filt[fcf_pkg::CH_REAR_RIGHT]  = rear_right_filtered;
                got.full = history_full;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: output transfer with no result pending", $time);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    n_checked <= n_checked + 1;
                    for (int c = 0; c < fcf_pkg::CHANNELS; c++)
                        if (got.filt[c] !== want.filt[c])
                        begin
                            $display("%0t: %s_filtered expected %0d actual %0d",
                                     $time, ch_name[c], want.filt[c], got.filt[c]);
                            errors++;
                        end
                    if (got.full !== want.full)
                    begin
                        $display("%0t: history_full expected %0b actual %0b",
                                 $time, want.full, got.full);
                        errors++;
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                in_word[fcf_pkg::CH_FRONT_LEFT]  = front_left_sample;
                in_word[fcf_pkg::CH_FRONT_RIGHT] = front_right_sample;
                in_word[fcf_pkg::CH_REAR_LEFT]   = rear_left_sample;
                in_word[fcf_pkg::CH_REAR_RIGHT]  = rear_right_sample;
                expected_q.push_back(filter_step(in_word));
                n_predicted <= n_predicted + 1;
            end
        end
    end

endmodule

[tb/tb_four_channel_fir_filter.sv]
`timescale 1ns / 100ps
// Testbench top for the four channel FIR filter: clock, reset, stimulus and verdict.
module tb_four_channel_fir_filter;

    localparam int TAP_COUNT     = 8;
    // Time one item occupies the shared MAC; the settle wait adds margin to it.
    localparam int ITEM_CYCLES   = 4 * TAP_COUNT + 5;
    localparam int SETTLE_CYCLES = ITEM_CYCLES + 8;
    localparam int IDLE_PCT      = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int SEGMENTS      = 12;
    localparam int SEG_ITEMS     = 150;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int IMPULSE_TAP   = 16384;    // 1.0 in Q2.14

    typedef enum int {
        TAPS_RANDOM,
        TAPS_MAX,
        TAPS_MIN,
        TAPS_SMALL,
        TAPS_IMPULSE,
        TAPS_EXTREME_MIX
    } tap_mode_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    fcf_pkg::sample_t              front_left_sample;
    fcf_pkg::sample_t              front_right_sample;
    fcf_pkg::sample_t              rear_left_sample;
    fcf_pkg::sample_t              rear_right_sample;
    logic                          out_valid;
    logic                          out_ready;
    fcf_pkg::result_t              front_left_filtered;
    fcf_pkg::result_t              front_right_filtered;
    fcf_pkg::result_t              rear_left_filtered;
    fcf_pkg::result_t              rear_right_filtered;
    logic                          history_full;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [fcf_pkg::CFG_IDX_W-1:0] cfg_index;
    fcf_pkg::tap_t                 cfg_data;

    int   outstanding;
    int   fail_count;
    int   cycles;
    logic idle_on;          // random idling on both sides
    int   hold_requests;    // bumped by stimulus to ask for a long receiver stall
    int   hold_served;

    four_channel_fir_filter #(
        .TAP_COUNT (TAP_COUNT)
    ) u_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .front_left_sample    (front_left_sample),
        .front_right_sample   (front_right_sample),
        .rear_left_sample     (rear_left_sample),
        .rear_right_sample    (rear_right_sample),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .front_left_filtered  (front_left_filtered),
        .front_right_filtered (front_right_filtered),
        .rear_left_filtered   (rear_left_filtered),
        .rear_right_filtered  (rear_right_filtered),
        .history_full         (history_full),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    fcf_checker #(
        .TAP_COUNT (TAP_COUNT)
    ) u_checker (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .front_left_sample    (front_left_sample),
        .front_right_sample   (front_right_sample),
        .rear_left_sample     (rear_left_sample),
        .rear_right_sample    (rear_right_sample),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .front_left_filtered  (front_left_filtered),
        .front_right_filtered (front_right_filtered),
        .rear_left_filtered   (rear_left_filtered),
        .rear_right_filtered  (rear_right_filtered),
        .history_full         (history_full),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .outstanding          (outstanding),
        .fail_count           (fail_count)
    );

    // 12 ns clock period.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: end the run if the cycle count runs past the limit.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[four_channel_fir_filter] ERROR");
        $finish;
    end

    // Receiver: stall at random, and serve each long hold-off request by
    // counting cycles here, so the sender keeps offering while results back up.
    initial
    begin : receiver
        int stall_left;
        stall_left  = 0;
        hold_served = 0;
        out_ready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != hold_served)
            begin
                hold_served++;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Mostly full-range values, with extremes and small values mixed in.
    function automatic fcf_pkg::sample_t rand_sample();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return fcf_pkg::sample_t'($urandom);
        if (r < 85)
        begin
            case ($urandom_range(3))
                0:       return 16'sh7FFF;
                1:       return 16'sh8000;
                2:       return 16'sh0000;
                default: return 16'shFFFF;
            endcase
        end
        return fcf_pkg::sample_t'($urandom_range(512) - 256);
    endfunction

    function automatic fcf_pkg::tap_t pick_tap(input tap_mode_t mode, input int k, input int pos);
        case (mode)
            TAPS_MAX:     return 16'sh7FFF;
            TAPS_MIN:     return 16'sh8000;
            TAPS_SMALL:   return fcf_pkg::tap_t'($urandom_range(4096) - 2048);
            TAPS_IMPULSE: return (k == pos) ? fcf_pkg::tap_t'(IMPULSE_TAP) : 16'sh0000;
            TAPS_EXTREME_MIX:
            begin
                case ($urandom_range(2))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    default: return 16'sh0000;
                endcase
            end
            default:      return fcf_pkg::tap_t'($urandom);
        endcase
    endfunction

    // One input transfer: optionally idle first, then hold valid and payload
    // until the block takes the item.
    task automatic send_item(input fcf_pkg::sample_t fl, input fcf_pkg::sample_t fr,
                             input fcf_pkg::sample_t rl, input fcf_pkg::sample_t rr);
        @(negedge clk);
        if (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        in_valid           <= 1'b1;
        front_left_sample  <= fl;
        front_right_sample <= fr;
        rear_left_sample   <= rl;
        rear_right_sample  <= rr;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic write_reg(input logic [fcf_pkg::CFG_IDX_W-1:0] idx, input fcf_pkg::tap_t val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Pause the sender until every expected result has come back, then let
    // the MAC settle so tap writes land on an idle block.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_taps(input tap_mode_t mode);
        int pos;
        pos = $urandom_range(fcf_pkg::MAX_TAPS - 1);
        for (int k = 0; k < fcf_pkg::MAX_TAPS; k++)
            write_reg(k[fcf_pkg::CFG_IDX_W-1:0], pick_tap(mode, k, pos));
        // Hit an unused index now and then; the block must drop it.
        if ($urandom_range(1) == 1)
            write_reg(fcf_pkg::CFG_IDX_W'($urandom_range((1 << fcf_pkg::CFG_IDX_W) - 1,
                                                         fcf_pkg::MAX_TAPS)),
                      fcf_pkg::tap_t'($urandom));
    endtask

    initial
    begin : stimulus
        tap_mode_t mode;
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        front_left_sample  = '0;
        front_right_sample = '0;
        rear_left_sample   = '0;
        rear_right_sample  = '0;
        cfg_valid          = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        idle_on            = 1'b1;
        hold_requests      = 0;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Reset taps: the first items see empty slots as zero, and the flag
        // must rise with the eighth transfer and stay up.
        send_item(16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF);
        send_item(16'sh8000, 16'sh7FFF, 16'sh0001, 16'sh0000);
        for (int i = 0; i < 8; i++)
            send_item(i[0] ? 16'sh5555 : 16'shAAAA, i[0] ? 16'shAAAA : 16'sh5555,
                      rand_sample(), rand_sample());

        // Every tap and every sample at the most negative value: the sum
        // reaches +2^19 and must saturate.
        wait_idle();
        load_taps(TAPS_MIN);
        for (int i = 0; i < 8; i++)
            send_item(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);

        // Single tiny tap: negative sums must floor toward minus infinity.
        // Also write the top index, which the block must ignore.
        wait_idle();
        write_reg('0, 16'sh0001);
        for (int k = 1; k < fcf_pkg::MAX_TAPS; k++)
            write_reg(k[fcf_pkg::CFG_IDX_W-1:0], 16'sh0000);
        write_reg('1, 16'sh7FFF);
        send_item(16'shFFFF, 16'sh0001, 16'shFFFE, 16'sh3FFF);
        send_item(16'sh8000, 16'shC001, 16'sh7FFF, 16'shFFFF);

        // Random segments, each under its own tap setting.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_idle();
            mode = tap_mode_t'(seg % 6);
            if (seg >= 6 && $urandom_range(1) == 1)
                mode = TAPS_RANDOM;
            load_taps(mode);
            idle_on = (seg != 5);
            if (seg == 2)
                hold_requests++;
            for (int i = 0; i < SEG_ITEMS; i++)
                send_item(rand_sample(), rand_sample(), rand_sample(), rand_sample());
        end

        @(negedge clk);
        in_valid <= 1'b0;
        idle_on  = 1'b1;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("[four_channel_fir_filter] OK");
        else
            $display("[four_channel_fir_filter] ERROR");
        $finish;
    end

endmodule
